// ===== hdl/cdls_pkg.sv =====
`default_nettype none
package cdls_pkg;

   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 14;
   localparam int SPEED_W     = 14;
   localparam int MARGIN_W    = 11;

   localparam logic [1:0] MODE_START = 2'd0;
   localparam logic [1:0] MODE_TICK  = 2'd1;
   localparam logic [1:0] MODE_STOP  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] REG_UPPER_SPEED  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_LOWER_SPEED  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_LOAD_POWER   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_UPPER_MARGIN = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_LOWER_MARGIN = 3'd4;

   localparam logic [MARGIN_W-1:0] UPPER_MARGIN_RESET = 11'd200;
   localparam logic [MARGIN_W-1:0] LOWER_MARGIN_RESET = 11'd300;

   localparam logic [SPEED_W-1:0] SPEED_MAX  = 14'h3FFF;
   // 5 km/h in units of 0.01 km/h.
   localparam logic [15:0]        STOP_SPEED = 16'd500;

   localparam logic [2:0] PHASE_CODE_IDLE  = 3'd0;
   localparam logic [2:0] PHASE_CODE_BEAM  = 3'd1;
   localparam logic [2:0] PHASE_CODE_ACCEL = 3'd2;
   localparam logic [2:0] PHASE_CODE_SLIP  = 3'd3;
   localparam logic [2:0] PHASE_CODE_DONE  = 3'd4;
   localparam logic [2:0] PHASE_CODE_ERROR = 3'd5;

   typedef enum logic [5:0] {
      PH_IDLE  = 6'b000001,
      PH_BEAM  = 6'b000010,
      PH_ACCEL = 6'b000100,
      PH_SLIP  = 6'b001000,
      PH_DONE  = 6'b010000,
      PH_ERROR = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [SPEED_W-1:0]  upper_speed;
      logic [SPEED_W-1:0]  lower_speed;
      logic [MARGIN_W-1:0] upper_margin;
      logic [MARGIN_W-1:0] lower_margin;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic        comm_ok;
      logic        beam_down;
      logic [15:0] speed;
      logic [15:0] timer_ms;
   } item_type;

   typedef struct packed {
      phase_type          phase;
      logic               error;
      logic [SPEED_W-1:0] upper_thr;
      logic [SPEED_W-1:0] lower_thr;
      logic [15:0]        load_time;
   } state_type;

   typedef struct packed {
      logic cmd_control_off;
      logic cmd_setup;
      logic cmd_motor_on;
      logic cmd_motor_off;
      logic cmd_timer_start;
      logic cmd_timer_stop;
      logic cmd_power_mode_on;
      logic finished;
   } cmd_type;

   function automatic logic [2:0] phase_code(input phase_type ph);
      logic [2:0] code;
      unique case (ph)
         PH_IDLE:  code = PHASE_CODE_IDLE;
         PH_BEAM:  code = PHASE_CODE_BEAM;
         PH_ACCEL: code = PHASE_CODE_ACCEL;
         PH_SLIP:  code = PHASE_CODE_SLIP;
         PH_DONE:  code = PHASE_CODE_DONE;
         PH_ERROR: code = PHASE_CODE_ERROR;
         default:  code = PHASE_CODE_IDLE;
      endcase
      return code;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/cdls_csr.sv =====
`default_nettype none
module cdls_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [cdls_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [cdls_pkg::CSR_DATA_W-1:0]     csr_data,
   output cdls_pkg::cfg_type                        cfg
);

   cdls_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            cdls_pkg::REG_UPPER_SPEED:  cfg_in.upper_speed  = csr_data;
            cdls_pkg::REG_LOWER_SPEED:  cfg_in.lower_speed  = csr_data;
            // The power target register is accepted but not stored; nothing here uses it.
            cdls_pkg::REG_LOAD_POWER:   cfg_in = cfg_ff;
            cdls_pkg::REG_UPPER_MARGIN: cfg_in.upper_margin = csr_data[cdls_pkg::MARGIN_W-1:0];
            cdls_pkg::REG_LOWER_MARGIN: cfg_in.lower_margin = csr_data[cdls_pkg::MARGIN_W-1:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.upper_speed  <= '0;
         cfg_ff.lower_speed  <= '0;
         cfg_ff.upper_margin <= cdls_pkg::UPPER_MARGIN_RESET;
         cfg_ff.lower_margin <= cdls_pkg::LOWER_MARGIN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/cdls_step.sv =====
`default_nettype none
module cdls_step (
   input  wire cdls_pkg::item_type  item,
   input  wire cdls_pkg::state_type state,
   input  wire cdls_pkg::cfg_type   cfg,
   output cdls_pkg::state_type state_next,
   output cdls_pkg::cmd_type   cmd
);

   logic [cdls_pkg::SPEED_W:0]   upper_sum;
   logic [cdls_pkg::SPEED_W-1:0] upper_thr;
   logic [cdls_pkg::SPEED_W-1:0] lower_thr;

   always_comb begin
      upper_sum = {1'b0, cfg.upper_speed}
                + {{(cdls_pkg::SPEED_W + 1 - cdls_pkg::MARGIN_W){1'b0}}, cfg.upper_margin};
      upper_thr = upper_sum[cdls_pkg::SPEED_W] ? cdls_pkg::SPEED_MAX
                                               : upper_sum[cdls_pkg::SPEED_W-1:0];
      if (cfg.lower_speed > {{(cdls_pkg::SPEED_W - cdls_pkg::MARGIN_W){1'b0}}, cfg.lower_margin})
         lower_thr = cfg.lower_speed
                   - {{(cdls_pkg::SPEED_W - cdls_pkg::MARGIN_W){1'b0}}, cfg.lower_margin};
      else
         lower_thr = '0;
   end

   always_comb begin
      state_next = state;
      cmd        = '0;
      unique case (item.mode)
         cdls_pkg::MODE_START: begin
            state_next.upper_thr = upper_thr;
            state_next.lower_thr = lower_thr;
            state_next.load_time = '0;
            cmd.cmd_control_off  = 1'b1;
            if (!item.comm_ok) begin
               state_next.phase = cdls_pkg::PH_ERROR;
               state_next.error = 1'b1;
            end else begin
               cmd.cmd_setup = 1'b1;
               if (item.beam_down) begin
                  cmd.cmd_motor_on = 1'b1;
                  state_next.phase = cdls_pkg::PH_ACCEL;
               end else begin
                  state_next.phase = cdls_pkg::PH_BEAM;
               end
            end
         end
         cdls_pkg::MODE_TICK: begin
            unique case (state.phase)
               cdls_pkg::PH_BEAM: begin
                  if (!item.comm_ok) begin
                     state_next.phase = cdls_pkg::PH_ERROR;
                     state_next.error = 1'b1;
                  end else if (item.beam_down) begin
                     cmd.cmd_motor_on = 1'b1;
                     state_next.phase = cdls_pkg::PH_ACCEL;
                  end
               end
               cdls_pkg::PH_ACCEL: begin
                  if (!item.comm_ok) begin
                     state_next.phase = cdls_pkg::PH_ERROR;
                     state_next.error = 1'b1;
                  end else if (item.speed > {2'b00, state.upper_thr}) begin
                     cmd.cmd_motor_off     = 1'b1;
                     cmd.cmd_timer_start   = 1'b1;
                     cmd.cmd_power_mode_on = 1'b1;
                     state_next.phase      = cdls_pkg::PH_SLIP;
                  end
               end
               cdls_pkg::PH_SLIP: begin
                  if (!item.comm_ok) begin
                     state_next.phase = cdls_pkg::PH_ERROR;
                     state_next.error = 1'b1;
                  end else if (item.speed > {2'b00, state.lower_thr}) begin
                     state_next.load_time = item.timer_ms;
                  end else if (item.speed < cdls_pkg::STOP_SPEED) begin
                     cmd.cmd_timer_stop  = 1'b1;
                     cmd.cmd_control_off = 1'b1;
                     cmd.finished        = 1'b1;
                     state_next.phase    = cdls_pkg::PH_DONE;
                  end
               end
               default: state_next = state;
            endcase
         end
         cdls_pkg::MODE_STOP: begin
            cmd.cmd_motor_off   = 1'b1;
            cmd.cmd_timer_stop  = 1'b1;
            cmd.cmd_control_off = 1'b1;
            state_next.phase    = cdls_pkg::PH_IDLE;
         end
         default: state_next = state;
      endcase
   end

endmodule
`default_nettype wire

// ===== hdl/coastdown_load_test_sequencer.sv =====
// Constant-load coast-down test sequencer for a chassis dynamometer.
// req channel: one beat per step. req_tuser carries the mode (start, tick or
// stop); req_tdata carries the device access result, the beam-down bit, the
// roller speed and the timer 1 reading. rsp channel: exactly one beat per
// request beat, in order, carrying the phase, the sticky error code, the load
// time and the command pulses for that step. csr channel: register writes,
// always ready, to be issued only while no request is in flight.
// A request beat that is taken lands in the input register, is evaluated there
// and is stored in the result register, which drives rsp.
// Throughput: one beat per cycle. The whole step is one pass of compare logic
// between the input register and the result register, with the sequencer state
// updated in the same edge; beats never wait on each other unless rsp stalls.
// A stalled rsp beat holds; one more request is absorbed into the input
// register, after which req_tready falls until rsp_tready returns.
// Reset (synchronous, active high) empties both registers, returns the
// sequencer to idle with no error and zero thresholds and load time, and loads
// the margins with their defaults (2 km/h above, 3 km/h below).
`default_nettype none
module coastdown_load_test_sequencer (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [0] comm_ok, [1] beam_down, [17:2] speed, [33:18] timer_ms, [39:34] zero
   input  wire logic [cdls_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [1:0] mode
   input  wire logic [1:0]                          req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [2:0] phase, [3] error_code, [19:4] load_time, [20] cmd_control_off,
   // [21] cmd_setup, [22] cmd_motor_on, [23] cmd_motor_off,
   // [24] cmd_timer_start, [25] cmd_timer_stop, [26] cmd_power_mode_on,
   // [27] finished, [31:28] zero
   output logic [cdls_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [cdls_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [cdls_pkg::CSR_DATA_W-1:0]     csr_data
);

   cdls_pkg::cfg_type   cfg;
   cdls_pkg::item_type  item_ff, item_in;
   cdls_pkg::state_type state_ff, state_next;
   cdls_pkg::cmd_type   cmd;
   logic                item_valid_ff, item_valid_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [cdls_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                advance;
   logic                req_take;

   cdls_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   cdls_step u_step (
      .item       (item_ff),
      .state      (state_ff),
      .cfg        (cfg),
      .state_next (state_next),
      .cmd        (cmd)
   );

   assign advance    = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      item_valid_in = item_valid_ff;
      item_in       = item_ff;
      if (req_take) begin
         item_valid_in     = 1'b1;
         item_in.mode      = req_tuser;
         item_in.comm_ok   = req_tdata[0];
         item_in.beam_down = req_tdata[1];
         item_in.speed     = req_tdata[17:2];
         item_in.timer_ms  = req_tdata[33:18];
      end else if (advance) begin
         item_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {4'b0000, cmd.finished, cmd.cmd_power_mode_on, cmd.cmd_timer_stop,
                         cmd.cmd_timer_start, cmd.cmd_motor_off, cmd.cmd_motor_on,
                         cmd.cmd_setup, cmd.cmd_control_off, state_next.load_time,
                         state_next.error, cdls_pkg::phase_code(state_next.phase)};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff      <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         state_ff.phase     <= cdls_pkg::PH_IDLE;
         state_ff.error     <= 1'b0;
         state_ff.upper_thr <= '0;
         state_ff.lower_thr <= '0;
         state_ff.load_time <= '0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
`default_nettype wire

// ===== hdl/cdls_checker.sv =====
`default_nettype none
module cdls_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [cdls_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // A held result beat keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] != 3'd6 && rsp_tdata[2:0] != 3'd7)
      else $error("phase code out of range");

   // Completion is reported only together with the finished phase and the
   // timer stop and control off commands.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[27] |->
         rsp_tdata[2:0] == cdls_pkg::PHASE_CODE_DONE && rsp_tdata[25] && rsp_tdata[20])
      else $error("finished pulse without completion commands");

   // A setup command always comes with control off and a cleared load time.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[21] |->
         rsp_tdata[20] && rsp_tdata[15:4] == 12'd0 && rsp_tdata[19:16] == 4'd0)
      else $error("setup without control off and cleared load time");

endmodule

bind coastdown_load_test_sequencer cdls_checker u_cdls_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

// ===== tb/tb_coastdown_load_test_sequencer.sv =====
`default_nettype none
module tb_coastdown_load_test_sequencer;
   import cdls_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // The package has no name for the unused mode value; the block must ignore it.
   localparam logic [1:0] MODE_IGNORED = 2'd3;
   localparam int         STALL_LIMIT  = 3000;
   localparam int         ITEMS_PER_SETTING = 320;
   localparam int         SETTING_COUNT = 6;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   // [0] comm_ok, [1] beam_down, [17:2] speed, [33:18] timer_ms, [39:34] zero
   logic [REQ_DATA_W-1:0]   req_tdata;
   // [1:0] mode
   logic [1:0]              req_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   // [2:0] phase, [3] error_code, [19:4] load_time, [27:20] command pulses
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0]   csr_data;

   bit long_hold_req;
   int unsigned quiet_cycles;

   typedef struct packed {
      logic [2:0]  phase;
      logic        error_code;
      logic [15:0] load_time;
      cmd_type     cmds;
   } step_result_type;

   class coastdown_scoreboard;
      logic [SPEED_W-1:0]  upper_speed;
      logic [SPEED_W-1:0]  lower_speed;
      logic [SPEED_W-1:0]  load_power;
      logic [MARGIN_W-1:0] upper_margin;
      logic [MARGIN_W-1:0] lower_margin;
      logic [2:0]          phase;
      logic                error_flag;
      logic [SPEED_W-1:0]  upper_thr;
      logic [SPEED_W-1:0]  lower_thr;
      logic [15:0]         load_time;
      step_result_type     expected_steps[$];
      int                  errors;

      function new();
         upper_speed  = '0;
         lower_speed  = '0;
         load_power   = '0;
         upper_margin = UPPER_MARGIN_RESET;
         lower_margin = LOWER_MARGIN_RESET;
         phase        = PHASE_CODE_IDLE;
         error_flag   = 1'b0;
         upper_thr    = '0;
         lower_thr    = '0;
         load_time    = '0;
         errors       = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            REG_UPPER_SPEED:  upper_speed  = val;
            REG_LOWER_SPEED:  lower_speed  = val;
            REG_LOAD_POWER:   load_power   = val;
            REG_UPPER_MARGIN: upper_margin = val[MARGIN_W-1:0];
            REG_LOWER_MARGIN: lower_margin = val[MARGIN_W-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_steps.size();
      endfunction

      // Advances the sequencer copy by one accepted request and queues the reply.
      function void note_request(logic [1:0] mode, logic ok, logic beam,
                                 logic [15:0] speed, logic [15:0] timer_ms);
         step_result_type r;
         logic [SPEED_W:0] upper_sum;
         r.cmds = '0;
         case (mode)
            MODE_START: begin
               upper_sum = {1'b0, upper_speed}
                         + {{(SPEED_W + 1 - MARGIN_W){1'b0}}, upper_margin};
               upper_thr = (upper_sum > {1'b0, SPEED_MAX}) ? SPEED_MAX
                                                           : upper_sum[SPEED_W-1:0];
               lower_thr = (lower_speed > {{(SPEED_W - MARGIN_W){1'b0}}, lower_margin})
                         ? lower_speed - {{(SPEED_W - MARGIN_W){1'b0}}, lower_margin} : '0;
               load_time = '0;
               r.cmds.cmd_control_off = 1'b1;
               if (!ok) begin
                  phase      = PHASE_CODE_ERROR;
                  error_flag = 1'b1;
               end else begin
                  r.cmds.cmd_setup = 1'b1;
                  if (beam) begin
                     r.cmds.cmd_motor_on = 1'b1;
                     phase = PHASE_CODE_ACCEL;
                  end else begin
                     phase = PHASE_CODE_BEAM;
                  end
               end
            end
            MODE_TICK: begin
               if (phase == PHASE_CODE_BEAM || phase == PHASE_CODE_ACCEL ||
                   phase == PHASE_CODE_SLIP) begin
                  if (!ok) begin
                     phase      = PHASE_CODE_ERROR;
                     error_flag = 1'b1;
                  end else if (phase == PHASE_CODE_BEAM) begin
                     if (beam) begin
                        r.cmds.cmd_motor_on = 1'b1;
                        phase = PHASE_CODE_ACCEL;
                     end
                  end else if (phase == PHASE_CODE_ACCEL) begin
                     if (speed > {2'b00, upper_thr}) begin
                        r.cmds.cmd_motor_off     = 1'b1;
                        r.cmds.cmd_timer_start   = 1'b1;
                        r.cmds.cmd_power_mode_on = 1'b1;
                        phase = PHASE_CODE_SLIP;
                     end
                  end else begin
                     if (speed > {2'b00, lower_thr}) begin
                        load_time = timer_ms;
                     end else if (speed < STOP_SPEED) begin
                        r.cmds.cmd_timer_stop  = 1'b1;
                        r.cmds.cmd_control_off = 1'b1;
                        r.cmds.finished        = 1'b1;
                        phase = PHASE_CODE_DONE;
                     end
                  end
               end
            end
            MODE_STOP: begin
               r.cmds.cmd_motor_off   = 1'b1;
               r.cmds.cmd_timer_stop  = 1'b1;
               r.cmds.cmd_control_off = 1'b1;
               phase = PHASE_CODE_IDLE;
            end
            default: ;
         endcase
         r.phase      = phase;
         r.error_code = error_flag;
         r.load_time  = load_time;
         expected_steps.push_back(r);
      endfunction

      function void check_field(string name, logic [15:0] want, logic [15:0] got);
         if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_reply(logic [RSP_DATA_W-1:0] data);
         step_result_type e;
         if (expected_steps.size() == 0) begin
            $error("reply beat %h arrived with no request outstanding", data);
            errors++;
            return;
         end
         e = expected_steps.pop_front();
         check_field("phase", 16'(e.phase), 16'(data[2:0]));
         check_field("error_code", 16'(e.error_code), 16'(data[3]));
         check_field("load_time", e.load_time, data[19:4]);
         check_field("cmd_control_off", 16'(e.cmds.cmd_control_off), 16'(data[20]));
         check_field("cmd_setup", 16'(e.cmds.cmd_setup), 16'(data[21]));
         check_field("cmd_motor_on", 16'(e.cmds.cmd_motor_on), 16'(data[22]));
         check_field("cmd_motor_off", 16'(e.cmds.cmd_motor_off), 16'(data[23]));
         check_field("cmd_timer_start", 16'(e.cmds.cmd_timer_start), 16'(data[24]));
         check_field("cmd_timer_stop", 16'(e.cmds.cmd_timer_stop), 16'(data[25]));
         check_field("cmd_power_mode_on", 16'(e.cmds.cmd_power_mode_on), 16'(data[26]));
         check_field("finished", 16'(e.cmds.finished), 16'(data[27]));
      endfunction
   endclass

   coastdown_scoreboard sb;

   coastdown_load_test_sequencer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_reply(rsp_tdata);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("** coastdown_load_test_sequencer: FAILED **");
         $finish;
      end
   end

   // Reply side: stretches of steady, random and patterned backpressure, plus a
   // long hold-off on request so that the block fills and stalls its input.
   initial begin
      int unsigned kind;
      int unsigned len;
      int unsigned cnt;
      rsp_tready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (80) @(posedge clock);
         end
         kind = $urandom_range(0, 3);
         len  = $urandom_range(5, 60);
         for (cnt = 0; cnt < len; cnt++) begin
            case (kind)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= (cnt % 3 == 0);
               default: rsp_tready <= ($urandom_range(0, 7) != 0);
            endcase
            @(posedge clock);
         end
      end
   end

   task automatic send_item(logic [1:0] mode, logic ok, logic beam,
                            logic [15:0] speed, logic [15:0] timer_ms);
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {6'b0, timer_ms, speed, beam, ok};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(mode, ok, beam, speed, timer_ms);
   endtask

   task automatic wait_replies_done();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_registers(logic [CSR_DATA_W-1:0] up_speed,
                                  logic [CSR_DATA_W-1:0] lo_speed,
                                  logic [CSR_DATA_W-1:0] power,
                                  logic [CSR_DATA_W-1:0] up_margin,
                                  logic [CSR_DATA_W-1:0] lo_margin);
      logic [CSR_INDEX_W-1:0] idx [5];
      logic [CSR_DATA_W-1:0]  val [5];
      int i;
      idx[0] = REG_UPPER_SPEED;  val[0] = up_speed;
      idx[1] = REG_LOWER_SPEED;  val[1] = lo_speed;
      idx[2] = REG_LOAD_POWER;   val[2] = power;
      idx[3] = REG_UPPER_MARGIN; val[3] = up_margin;
      idx[4] = REG_LOWER_MARGIN; val[4] = lo_margin;
      for (i = 0; i < 5; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= val[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         sb.write_reg(idx[i], val[i]);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic apply_setting(int which);
      case (which)
         0: write_registers(14'd1000, 14'd800, 14'd5000, 14'd200, 14'd300);
         1: write_registers(14'd0, 14'd0, 14'd0, 14'd0, 14'd0);
         2: write_registers(14'd9999, 14'd9999, 14'd9900, 14'd2000, 14'd2000);
         // Upper threshold saturates; the margin registers keep their low bits.
         3: write_registers(14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF);
         4: write_registers(14'($urandom_range(0, 9999)), 14'($urandom_range(0, 9999)),
                            14'($urandom_range(0, 9900)), 14'($urandom_range(0, 2000)),
                            14'($urandom_range(0, 2000)));
         default: write_registers(14'd300, 14'd200, 14'd1, 14'd2000, 14'd2000);
      endcase
   endtask

   // Walks every phase with thresholds of 1200 above and 500 below.
   task automatic run_directed();
      send_item(MODE_TICK, 1'b1, 1'b1, 16'd0, 16'd0);
      send_item(MODE_IGNORED, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF);
      send_item(MODE_START, 1'b0, 1'b1, 16'd0, 16'd0);
      send_item(MODE_TICK, 1'b1, 1'b1, 16'hFFFF, 16'd7);
      send_item(MODE_START, 1'b1, 1'b0, 16'd0, 16'd0);
      send_item(MODE_TICK, 1'b1, 1'b0, 16'hFFFF, 16'd1);
      send_item(MODE_TICK, 1'b0, 1'b1, 16'd0, 16'd2);
      send_item(MODE_START, 1'b1, 1'b0, 16'd0, 16'd0);
      send_item(MODE_TICK, 1'b1, 1'b1, 16'd0, 16'd3);
      send_item(MODE_TICK, 1'b1, 1'b0, 16'd1200, 16'd4);
      send_item(MODE_TICK, 1'b0, 1'b0, 16'hFFFF, 16'd5);
      send_item(MODE_START, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF);
      send_item(MODE_TICK, 1'b1, 1'b0, 16'hFFFF, 16'd6);
      send_item(MODE_TICK, 1'b1, 1'b0, 16'd501, 16'hFFFF);
      send_item(MODE_TICK, 1'b1, 1'b0, 16'd500, 16'd1234);
      send_item(MODE_TICK, 1'b0, 1'b0, 16'd0, 16'd0);
      send_item(MODE_START, 1'b1, 1'b1, 16'd0, 16'd0);
      send_item(MODE_TICK, 1'b1, 1'b1, 16'd1201, 16'd0);
      send_item(MODE_TICK, 1'b1, 1'b1, 16'd0, 16'd0);
      send_item(MODE_TICK, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF);
      send_item(MODE_IGNORED, 1'b0, 1'b0, 16'd0, 16'd0);
      send_item(MODE_STOP, 1'b1, 1'b1, 16'd0, 16'd0);
      send_item(MODE_START, 1'b1, 1'b1, 16'd0, 16'd0);
      send_item(MODE_STOP, 1'b0, 1'b0, 16'hFFFF, 16'hFFFF);
      send_item(MODE_TICK, 1'b0, 1'b0, 16'd0, 16'd0);
   endtask

   // Mostly steps that push the current test forward, with some noise mixed in.
   task automatic pick_item(output logic [1:0] mode, output logic ok, output logic beam,
                            output logic [15:0] speed, output logic [15:0] timer_ms);
      int unsigned r;
      int unsigned s;
      r        = $urandom_range(0, 99);
      mode     = MODE_TICK;
      ok       = 1'b1;
      beam     = 1'($urandom_range(0, 1));
      speed    = 16'($urandom_range(0, 65535));
      timer_ms = 16'($urandom_range(0, 65535));
      if (r < 3) begin
         mode = MODE_STOP;
      end else if (r < 5) begin
         mode = MODE_IGNORED;
      end else if (r < 8) begin
         mode = MODE_START;
      end else if (r < 12) begin
         ok = 1'($urandom_range(0, 1));
      end else if (r < 14) begin
         ok = 1'b0;
      end else begin
         case (sb.phase)
            PHASE_CODE_BEAM: beam = ($urandom_range(0, 2) == 0);
            PHASE_CODE_ACCEL: begin
               if ($urandom_range(0, 1)) speed = 16'($urandom_range(65535, sb.upper_thr + 1));
               else speed = 16'($urandom_range(sb.upper_thr, 0));
            end
            PHASE_CODE_SLIP: begin
               s = $urandom_range(0, 3);
               if (s < 2) speed = 16'($urandom_range(65535, sb.lower_thr + 1));
               else if (s == 2 && {2'b00, sb.lower_thr} >= STOP_SPEED)
                  speed = 16'($urandom_range(sb.lower_thr, STOP_SPEED));
               else speed = 16'($urandom_range(STOP_SPEED - 1, 0));
            end
            default: begin
               mode = MODE_START;
               ok   = ($urandom_range(0, 24) != 0);
            end
         endcase
      end
   endtask

   task automatic run_random(int setting, int count);
      logic [1:0]  mode;
      logic        ok;
      logic        beam;
      logic [15:0] speed;
      logic [15:0] timer_ms;
      int n;
      int burst_left;
      burst_left = 0;
      for (n = 0; n < count; n++) begin
         if (setting == 1 && n == 100) long_hold_req = 1'b1;
         if (setting == 2 && n == 150) wait_replies_done();
         if (burst_left == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 16);
         end
         burst_left--;
         pick_item(mode, ok, beam, speed, timer_ms);
         send_item(mode, ok, beam, speed, timer_ms);
      end
   endtask

   initial begin
      int k;
      sb            = new();
      long_hold_req = 1'b0;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = MODE_TICK;
      csr_valid     = 1'b0;
      csr_index     = REG_UPPER_SPEED;
      csr_data      = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (k = 0; k < SETTING_COUNT; k++) begin
         wait_replies_done();
         apply_setting(k);
         if (k == 0) run_directed();
         run_random(k, ITEMS_PER_SETTING);
      end
      wait_replies_done();
      repeat (10) @(posedge clock);
      if (sb.pending() != 0) begin
         $error("%0d expected replies never arrived", sb.pending());
      end
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("** coastdown_load_test_sequencer: PASSED **");
      end else begin
         $display("** coastdown_load_test_sequencer: FAILED **");
      end
      $finish;
   end

endmodule
`default_nettype wire
